@@ rtl/core/psa_pkg.sv @@
// Shared types and constants for the pixel saturating ALU.
// Used by psa_front, psa_div_cell and pixel_saturating_alu_unit; no dependencies.
package psa_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_XOR   = 4'd3;
    localparam logic [3:0] OP_AND   = 4'd4;
    localparam logic [3:0] OP_OR    = 4'd5;
    localparam logic [3:0] OP_SADD  = 4'd6;
    localparam logic [3:0] OP_SSUB  = 4'd7;
    localparam logic [3:0] OP_SMUL  = 4'd8;
    localparam logic [3:0] OP_SDIV  = 4'd9;
    localparam logic [3:0] OP_SMOD  = 4'd10;
    localparam logic [3:0] OP_SXOR  = 4'd11;
    localparam logic [3:0] OP_SAND  = 4'd12;
    localparam logic [3:0] OP_SOR   = 4'd13;
    localparam logic [3:0] OP_SHR   = 4'd14;
    localparam logic [3:0] OP_SHL   = 4'd15;

    localparam logic [1:0] REG_OPERATION = 2'd0;
    localparam logic [1:0] REG_OFFSET    = 2'd1;
    localparam logic [1:0] REG_FACTOR    = 2'd2;

    localparam int CFG_DATA_BITS = 17;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_QUOT,
        KIND_REM
    } kind_t;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [16:0] signed_offset;
        logic [15:0]        unsigned_factor;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic        dbz;
        logic [15:0] dividend;
        logic [15:0] divisor;
        logic [15:0] rem;
        logic [15:0] quot;
        logic [15:0] result;
    } stage_t;

endpackage

@@ rtl/core/pixel_saturating_alu_unit.sv @@
// Top level of the pixel saturating ALU: configuration registers, input stage,
// divider cell chain and result register. Depends on psa_pkg, psa_front, psa_div_cell.
//
// Usage: write operation (index 0), signed_offset (index 1) and unsigned_factor
// (index 2) through cfg_write/cfg_index/cfg_data while no request is in flight.
// Index 3 is ignored. A request is taken at each rising edge with start high and
// busy low; busy is always low, so one request may be issued in every cycle.
// Each request gives one result on result_pixel and divide_by_zero, marked by
// done for exactly one cycle. Each request passes through the input register, the
// divider chain (one cell per quotient bit) and the result register in that order;
// every operation takes the same path, so results leave in request order at one per
// cycle.
// The receiver cannot stall; it must take each result in its done cycle.
// Reset clears all requests in flight and sets operation 0, signed_offset 0
// and unsigned_factor 1.
module pixel_saturating_alu_unit #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [psa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic [7:0]                         pixel_a,
    input  logic                               a_present,
    input  logic [7:0]                         pixel_b,
    input  logic                               b_present,
    output logic                               done,
    output logic [15:0]                        result_pixel,
    output logic                               divide_by_zero
);

    localparam int LATENCY = PIXEL_BITS + 2;

    psa_pkg::cfg_t cfg_reg;

    logic            accept;
    logic            chain_valid [0:PIXEL_BITS];
    psa_pkg::stage_t chain_data  [0:PIXEL_BITS];

    logic        done_reg;
    logic        done_next;
    logic [15:0] result_reg;
    logic [15:0] result_next;
    logic        dbz_reg;
    logic        dbz_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.operation       <= psa_pkg::OP_ADD;
            cfg_reg.signed_offset   <= '0;
            cfg_reg.unsigned_factor <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                psa_pkg::REG_OPERATION: cfg_reg.operation       <= cfg_data[3:0];
                psa_pkg::REG_OFFSET:    cfg_reg.signed_offset   <= $signed(cfg_data[16:0]);
                psa_pkg::REG_FACTOR:    cfg_reg.unsigned_factor <= cfg_data[15:0];
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    psa_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cfg       (cfg_reg),
        .pixel_a   (pixel_a),
        .a_present (a_present),
        .pixel_b   (pixel_b),
        .b_present (b_present),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar k = 0; k < PIXEL_BITS; k++)
    begin : g_cell
        psa_div_cell #(
            .BIT (PIXEL_BITS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    always_comb
    begin
        done_next = chain_valid[PIXEL_BITS];
        dbz_next  = chain_data[PIXEL_BITS].dbz;
        case (chain_data[PIXEL_BITS].kind)
            psa_pkg::KIND_QUOT: result_next = chain_data[PIXEL_BITS].quot;
            psa_pkg::KIND_REM:  result_next = chain_data[PIXEL_BITS].rem;
            default:            result_next = chain_data[PIXEL_BITS].result;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        dbz_reg    <= dbz_next;
    end

    assign done           = done_reg;
    assign result_pixel   = result_reg;
    assign divide_by_zero = dbz_reg;

    a_done_follows_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY)
    ) else $error("result strobe without a matching request");

    a_request_gives_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done
    ) else $error("request produced no result strobe");

    a_dbz_zero_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (result_pixel == 16'd0)
    ) else $error("divide by zero flagged with a nonzero result");

endmodule

@@ rtl/core/psa_front.sv @@
// Input stage: masks the pixels, computes every operation except divide and modulo,
// and loads the first stage record of the divider chain. Depends on psa_pkg.
module psa_front #(
    parameter int PIXEL_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  psa_pkg::cfg_t   cfg,
    input  logic [7:0]      pixel_a,
    input  logic            a_present,
    input  logic [7:0]      pixel_b,
    input  logic            b_present,
    output logic            out_valid,
    output psa_pkg::stage_t out_data
);

    localparam logic [15:0] MAX   = 16'((32'd1 << PIXEL_BITS) - 32'd1);
    localparam logic [4:0]  PBITS = 5'(PIXEL_BITS);

    logic            valid_reg;
    psa_pkg::stage_t data_reg;
    psa_pkg::stage_t data_next;

    logic [15:0]        a;
    logic [15:0]        b;
    logic [15:0]        fmask;
    logic [16:0]        sum_ab;
    logic [31:0]        prod_ab;
    logic [31:0]        prod_af;
    logic [4:0]         sh;
    logic [31:0]        shl_full;
    logic signed [17:0] offset_ext;
    logic signed [17:0] a_ext;
    logic signed [17:0] sadd;
    logic signed [17:0] ssub;

    function automatic logic [15:0] clamp(input logic signed [17:0] v);
        logic [15:0] r;
        if (v < 18'sd0)
        begin
            r = '0;
        end
        else if (v > $signed({2'b00, MAX}))
        begin
            r = MAX;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sat32(input logic [31:0] v);
        return (v > {16'd0, MAX}) ? MAX : v[15:0];
    endfunction

    always_comb
    begin
        a          = a_present ? ({8'd0, pixel_a} & MAX) : '0;
        b          = b_present ? ({8'd0, pixel_b} & MAX) : '0;
        fmask      = cfg.unsigned_factor & MAX;
        sum_ab     = {1'b0, a} + {1'b0, b};
        prod_ab    = {16'd0, a} * {16'd0, b};
        prod_af    = {16'd0, a} * {16'd0, cfg.unsigned_factor};
        sh         = (cfg.unsigned_factor > {11'd0, PBITS}) ? PBITS
                                                             : cfg.unsigned_factor[4:0];
        shl_full   = {16'd0, a} << sh;
        offset_ext = {cfg.signed_offset[16], cfg.signed_offset};
        a_ext      = $signed({2'b00, a});
        sadd       = a_ext + offset_ext;
        ssub       = a_ext - offset_ext;

        data_next.kind     = psa_pkg::KIND_DIRECT;
        data_next.dbz      = 1'b0;
        data_next.dividend = a;
        data_next.divisor  = cfg.unsigned_factor;
        data_next.rem      = '0;
        data_next.quot     = '0;
        data_next.result   = '0;

        case (cfg.operation)
            psa_pkg::OP_ADD:  data_next.result = (sum_ab > {1'b0, MAX}) ? MAX : sum_ab[15:0];
            psa_pkg::OP_SUB:  data_next.result = (a > b) ? (a - b) : '0;
            psa_pkg::OP_MUL:  data_next.result = sat32(prod_ab);
            psa_pkg::OP_XOR:  data_next.result = a ^ b;
            psa_pkg::OP_AND:  data_next.result = a & b;
            psa_pkg::OP_OR:   data_next.result = a | b;
            psa_pkg::OP_SADD: data_next.result = clamp(sadd);
            psa_pkg::OP_SSUB: data_next.result = clamp(ssub);
            psa_pkg::OP_SMUL: data_next.result = sat32(prod_af);
            psa_pkg::OP_SDIV:
            begin
                if (cfg.unsigned_factor == 16'd0)
                begin
                    data_next.dbz = 1'b1;
                end
                else
                begin
                    data_next.kind = psa_pkg::KIND_QUOT;
                end
            end
            psa_pkg::OP_SMOD:
            begin
                if (cfg.unsigned_factor == 16'd0)
                begin
                    data_next.dbz = 1'b1;
                end
                else
                begin
                    data_next.kind = psa_pkg::KIND_REM;
                end
            end
            psa_pkg::OP_SXOR: data_next.result = a ^ fmask;
            psa_pkg::OP_SAND: data_next.result = a & fmask;
            psa_pkg::OP_SOR:  data_next.result = a | fmask;
            psa_pkg::OP_SHR:  data_next.result = a >> sh;
            default:          data_next.result = shl_full[15:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/psa_div_cell.sv @@
// One cell of the restoring divider chain: settles one quotient bit per cycle
// and hands the stage record to the next cell. Depends on psa_pkg.
module psa_div_cell #(
    parameter int BIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  psa_pkg::stage_t in_data,
    output logic            out_valid,
    output psa_pkg::stage_t out_data
);

    logic            valid_reg;
    psa_pkg::stage_t data_reg;
    psa_pkg::stage_t data_next;

    logic [16:0] rem_shift;
    logic [16:0] diff;
    logic        ge;

    always_comb
    begin
        rem_shift = {in_data.rem, in_data.dividend[BIT]};
        ge        = rem_shift >= {1'b0, in_data.divisor};
        diff      = rem_shift - {1'b0, in_data.divisor};

        data_next           = in_data;
        data_next.rem       = ge ? diff[15:0] : rem_shift[15:0];
        data_next.quot[BIT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
